@@ rtl/core/ppi_pkg.sv @@
// Shared types and constants for the polyline profile intersection unit.
package ppi_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COORDINATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH       = 2'd2;

  // Profile orientation codes.
  localparam logic ORIENT_VERTICAL   = 1'b0;
  localparam logic ORIENT_HORIZONTAL = 1'b1;

  // Job queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Queue occupancy flags seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_FINISH
  } back_state_t;

endpackage

@@ rtl/core/ppi_front.sv @@
// Front end: keeps the previous vertex, tests each new segment against the
// profile line and, on a hit, queues the operands of the interpolation.
module ppi_front #(
  parameter int COORD_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_orientation,
  input  logic signed [COORD_BITS-1:0]         cfg_coordinate,
  input  logic signed [COORD_BITS-1:0]         cfg_depth,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_BITS-1:0]         vertex_x,
  input  logic signed [COORD_BITS-1:0]         vertex_y,
  input  logic                                 starts_polyline,
  input  ppi_pkg::queue_stat_t                 q_stat,
  output logic                                 push,
  output logic [3*COORD_BITS+3*(COORD_BITS+1)+1:0] job
);

  localparam int MAG = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] prior_x;
  logic signed [COORD_BITS-1:0] prior_y;
  logic                         prior_valid;

  logic                         accept;
  logic signed [COORD_BITS-1:0] f1, g1, f2, g2, span_lo, span_hi;
  logic                         hit;
  logic signed [MAG-1:0]        num_a, num_b, den;
  logic [MAG-1:0]               mag_a, mag_b, mag_d;
  logic                         neg;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // Select the fixed axis (f) and the free axis (g) for the segment.
  always_comb begin
    if (cfg_orientation == ppi_pkg::ORIENT_VERTICAL) begin
      f1 = prior_x;
      g1 = prior_y;
      f2 = vertex_x;
      g2 = vertex_y;
    end else begin
      f1 = prior_y;
      g1 = prior_x;
      f2 = vertex_y;
      g2 = vertex_x;
    end
  end

  // Inclusive span test on the fixed axis.
  always_comb begin
    span_lo = (f1 < f2) ? f1 : f2;
    span_hi = (f1 < f2) ? f2 : f1;
    hit     = !starts_polyline && prior_valid &&
              (cfg_coordinate >= span_lo) && (cfg_coordinate <= span_hi);
  end

  // Differences one bit wider so that they never overflow, then magnitudes.
  always_comb begin
    num_a = {cfg_coordinate[COORD_BITS-1], cfg_coordinate} - {f1[COORD_BITS-1], f1};
    num_b = {g1[COORD_BITS-1], g1} - {g2[COORD_BITS-1], g2};
    den   = {f1[COORD_BITS-1], f1} - {f2[COORD_BITS-1], f2};
    mag_a = num_a[MAG-1] ? (~num_a + 1'b1) : num_a;
    mag_b = num_b[MAG-1] ? (~num_b + 1'b1) : num_b;
    mag_d = den[MAG-1]   ? (~den + 1'b1)   : den;
    neg   = num_a[MAG-1] ^ num_b[MAG-1] ^ den[MAG-1];
  end

  assign push = accept && hit;
  assign job  = {cfg_orientation, neg, cfg_coordinate, g1, cfg_depth, mag_a, mag_b, mag_d};

  // Previous vertex register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_x     <= '0;
      prior_y     <= '0;
      prior_valid <= 1'b0;
    end else if (accept) begin
      prior_x     <= vertex_x;
      prior_y     <= vertex_y;
      prior_valid <= 1'b1;
    end
  end

endmodule

@@ rtl/core/ppi_queue.sv @@
// Short job queue; the head entry is registered when it is popped.
module ppi_queue #(
  parameter int WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     rd_data,
  output ppi_pkg::queue_stat_t stat
);

  logic [WIDTH-1:0]              mem [ppi_pkg::QUEUE_DEPTH];
  logic [ppi_pkg::QPTR_W-1:0]    wr_ptr;
  logic [ppi_pkg::QPTR_W-1:0]    rd_ptr;
  logic [ppi_pkg::QCNT_W-1:0]    count;

  assign stat.full  = (count == ppi_pkg::QCNT_W'(ppi_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  // Storage write and registered read of the head entry.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
    if (pop) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/ppi_back.sv @@
// Back end: one multiply, a restoring divide at one quotient bit per cycle,
// then the signed correction onto the first vertex and an output register.
module ppi_back #(
  parameter int COORD_BITS = 32
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  ppi_pkg::queue_stat_t                     q_stat,
  output logic                                     pop,
  input  logic [3*COORD_BITS+3*(COORD_BITS+1)+1:0] job,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [COORD_BITS-1:0]                    cross_x,
  output logic [COORD_BITS-1:0]                    cross_y,
  output logic [COORD_BITS-1:0]                    cross_z
);

  localparam int MAG  = COORD_BITS + 1;
  localparam int CNTW = $clog2(MAG);

  // Job fields, valid from the cycle after the pop until the next pop.
  logic                         j_orient, j_neg;
  logic signed [COORD_BITS-1:0] j_coord, j_g1, j_depth;
  logic [MAG-1:0]               j_a, j_b, j_d;

  assign {j_orient, j_neg, j_coord, j_g1, j_depth, j_a, j_b, j_d} = job;

  ppi_pkg::back_state_t state, state_next;

  logic [MAG-1:0]        rem;
  logic [MAG-1:0]        low;
  logic [MAG-1:0]        quo;
  logic [CNTW-1:0]       cnt;
  logic [2*MAG-1:0]      product;
  logic [MAG:0]          shifted;
  logic                  q_bit;
  logic [COORD_BITS-1:0] q_use;
  logic [COORD_BITS-1:0] free_coord;
  logic                  out_free;
  logic                  load_out;

  assign out_free = !out_valid || out_ready;
  assign product  = j_a * j_b;
  assign shifted  = {rem, low[MAG-1]};
  assign q_bit    = (shifted >= {1'b0, j_d});

  // The quotient never exceeds the free-axis span; a zero fixed-axis span (the divisor) forces zero.
  assign q_use      = (j_d == '0) ? '0 : quo[COORD_BITS-1:0];
  assign free_coord = j_neg ? (j_g1 - q_use) : (j_g1 + q_use);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppi_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      ppi_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = ppi_pkg::BK_MUL;
        end
      end
      ppi_pkg::BK_MUL: begin
        state_next = ppi_pkg::BK_DIV;
      end
      ppi_pkg::BK_DIV: begin
        if (cnt == CNTW'(MAG - 1)) begin
          state_next = ppi_pkg::BK_FINISH;
        end
      end
      ppi_pkg::BK_FINISH: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ppi_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = ppi_pkg::BK_IDLE;
      end
    endcase
  end

  // Multiply and divide datapath.
  always_ff @(posedge clk) begin
    case (state)
      ppi_pkg::BK_MUL: begin
        rem <= product[2*MAG-1:MAG];
        low <= product[MAG-1:0];
        quo <= '0;
        cnt <= '0;
      end
      ppi_pkg::BK_DIV: begin
        rem <= q_bit ? MAG'(shifted - {1'b0, j_d}) : shifted[MAG-1:0];
        low <= {low[MAG-2:0], 1'b0};
        quo <= {quo[MAG-2:0], q_bit};
        cnt <= cnt + 1'b1;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // Output register; it holds a result while the next job is worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (j_orient == ppi_pkg::ORIENT_VERTICAL) begin
        cross_x <= j_coord;
        cross_y <= free_coord;
      end else begin
        cross_x <= free_coord;
        cross_y <= j_coord;
      end
      cross_z <= j_depth;
    end
  end

endmodule

@@ rtl/core/polyline_profile_intersect_unit.sv @@
// Channel    Direction  Handshake         Payload
// vertex     in         s_tvalid/tready   s_tdata {vertex_y, vertex_x}, s_tuser starts_polyline
// crossing   out        m_tvalid/tready   m_tdata {cross_z, cross_y, cross_x}
// config     in         cfg_we            cfg_index, cfg_data
//
// A vertex that misses the profile line only updates the front end's previous vertex.
// A hit goes through the back end in order: pop, one multiply,
// one quotient bit per cycle from the restoring divider, then the output load.
// The divider sets the rate; a four-entry job queue lets the front end keep
// taking vertices while it works, and the output register holds a stalled result.
// Reset is synchronous and clears configuration, previous vertex and queue.
module polyline_profile_intersect_unit #(
  parameter int COORD_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration write port.
  input  logic                                   cfg_we,
  input  logic [ppi_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [COORD_BITS-1:0]                  cfg_data,
  // Vertex input stream.
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // Fields from bit 0: vertex_x, vertex_y, zero fill.
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  // Fields from bit 0: starts_polyline.
  input  logic                                   s_tuser,
  // Intersection output stream.
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // Fields from bit 0: cross_x, cross_y, cross_z, zero fill.
  output logic [((3*COORD_BITS+7)/8)*8-1:0]      m_tdata
);

  localparam int MAG   = COORD_BITS + 1;
  localparam int JOB_W = 3*COORD_BITS + 3*MAG + 2;
  localparam int OUT_W = ((3*COORD_BITS+7)/8)*8;

  logic                         cfg_orientation;
  logic signed [COORD_BITS-1:0] cfg_coordinate;
  logic signed [COORD_BITS-1:0] cfg_depth;

  ppi_pkg::queue_stat_t q_stat;
  logic                 push, pop;
  logic [JOB_W-1:0]     job_in, job_out;
  logic [COORD_BITS-1:0] cross_x, cross_y, cross_z;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_orientation <= ppi_pkg::ORIENT_VERTICAL;
      cfg_coordinate  <= '0;
      cfg_depth       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ppi_pkg::CFG_ORIENTATION: cfg_orientation <= cfg_data[0];
        ppi_pkg::CFG_COORDINATE:  cfg_coordinate  <= cfg_data;
        ppi_pkg::CFG_DEPTH:       cfg_depth       <= cfg_data;
        default: begin
          cfg_orientation <= cfg_orientation;
        end
      endcase
    end
  end

  ppi_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_orientation (cfg_orientation),
    .cfg_coordinate  (cfg_coordinate),
    .cfg_depth       (cfg_depth),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .vertex_x        (s_tdata[COORD_BITS-1:0]),
    .vertex_y        (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .starts_polyline (s_tuser),
    .q_stat          (q_stat),
    .push            (push),
    .job             (job_in)
  );

  ppi_queue #(.WIDTH(JOB_W)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (job_in),
    .pop     (pop),
    .rd_data (job_out),
    .stat    (q_stat)
  );

  ppi_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop       (pop),
    .job       (job_out),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cross_x   (cross_x),
    .cross_y   (cross_y),
    .cross_z   (cross_z)
  );

  assign m_tdata = OUT_W'({cross_z, cross_y, cross_x});

endmodule

@@ rtl/core/ppi_checker.sv @@
// Port-level checks for the polyline profile intersection unit.
module ppi_checker #(
  parameter int COORD_BITS = 32
) (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   cfg_we,
  input logic [ppi_pkg::CFG_IDX_W-1:0]          cfg_index,
  input logic [COORD_BITS-1:0]                  cfg_data,
  input logic                                   s_tready,
  input logic                                   m_tvalid,
  input logic                                   m_tready,
  input logic [((3*COORD_BITS+7)/8)*8-1:0]      m_tdata
);

  // Shadow copies of the configuration seen on the port.
  logic                  sh_orient;
  logic [COORD_BITS-1:0] sh_coord;
  logic [COORD_BITS-1:0] sh_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_orient <= ppi_pkg::ORIENT_VERTICAL;
      sh_coord  <= '0;
      sh_depth  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == ppi_pkg::CFG_ORIENTATION) begin
        sh_orient <= cfg_data[0];
      end
      if (cfg_index == ppi_pkg::CFG_COORDINATE) begin
        sh_coord <= cfg_data;
      end
      if (cfg_index == ppi_pkg::CFG_DEPTH) begin
        sh_depth <= cfg_data;
      end
    end
  end

  // Reset empties the output register and the job queue.
  a_reset_clears: assert property (@(posedge clk) rst |=> (!m_tvalid && s_tready))
    else $error("output valid or queue full after reset");

  // A stalled result holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // Every result carries the configured depth.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3*COORD_BITS-1:2*COORD_BITS] == sh_depth))
    else $error("result depth differs from configuration");

  // The coordinate on the fixed axis equals the profile coordinate.
  a_fixed_axis: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      ((sh_orient == ppi_pkg::ORIENT_VERTICAL && m_tdata[COORD_BITS-1:0] == sh_coord) ||
       (sh_orient == ppi_pkg::ORIENT_HORIZONTAL &&
        m_tdata[2*COORD_BITS-1:COORD_BITS] == sh_coord)))
    else $error("result is off the profile line");

endmodule

bind polyline_profile_intersect_unit ppi_checker #(.COORD_BITS(COORD_BITS)) u_ppi_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);
